### rtl/rqts_pkg.sv
// Shared types, constants and lookup tables for the rotating queue task scheduler.
`timescale 1ns / 1ps

package rqts_pkg;

    // Sizing of the scheduler.
    localparam int MAX_THREADS = 64;
    localparam int RING_SLOTS  = 9;

    // Field widths fixed by the interface.
    localparam int TID_W     = 6;
    localparam int CLS_W     = 2;
    localparam int OFF_W     = 8;
    localparam int LEN_W     = 7;
    localparam int SLICE_W   = 26;
    localparam int FREQ_W    = 32;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    // Derived sizes.
    localparam int QUEUE_COUNT = RING_SLOTS + 2;
    localparam int QW          = $clog2(QUEUE_COUNT);
    localparam int PTR_W       = $clog2(RING_SLOTS);
    localparam int LINK_AW     = $clog2(MAX_THREADS);
    localparam int OFF_COUNT   = 1 << OFF_W;
    localparam int TID_COUNT   = 1 << TID_W;

    localparam logic [QW-1:0]    RT_QUEUE   = QW'(RING_SLOTS);
    localparam logic [QW-1:0]    IDLE_QUEUE = QW'(RING_SLOTS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX    = '1;

    // Reciprocal for the time slice: floor(x / 100) = (x * SLICE_MUL) >> SLICE_SHIFT
    // for every 32-bit x.
    localparam int               SLICE_SHIFT = 38;
    localparam logic [63:0]      SLICE_MUL64 = ((64'd1 << SLICE_SHIFT) + 64'd99) / 64'd100;
    localparam logic [FREQ_W-1:0] SLICE_MUL  = SLICE_MUL64[FREQ_W-1:0];

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_NEXT   = 1'b1;

    // Thread classes.
    localparam logic [CLS_W-1:0] CLS_IDLE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_STD  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_RT   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_TIMER_FREQ = 1'b0;
    localparam logic REG_IDLE_ID    = 1'b1;

    // Input and result transactions.
    typedef struct packed {
        logic             command;
        logic [TID_W-1:0] thread_id;
        logic [CLS_W-1:0] thread_class;
        logic [OFF_W-1:0] slot_offset;
    } t_in_item;

    typedef struct packed {
        logic               preempt;
        logic [TID_W-1:0]   next_thread;
        logic [SLICE_W-1:0] slice_ticks;
    } t_out_item;

    typedef logic [PTR_W-1:0]   t_off_tab  [OFF_COUNT];
    typedef logic [LINK_AW-1:0] t_link_tab [TID_COUNT];

    // Ring distance reduced modulo the ring size.
    function automatic t_off_tab build_off_tab();
        t_off_tab tab;
        for (int i = 0; i < OFF_COUNT; i++) begin
            tab[i] = PTR_W'(i % RING_SLOTS);
        end
        return tab;
    endfunction

    // Link memory entry of a thread id.
    function automatic t_link_tab build_link_tab();
        t_link_tab tab;
        for (int i = 0; i < TID_COUNT; i++) begin
            tab[i] = LINK_AW'(i % MAX_THREADS);
        end
        return tab;
    endfunction

    localparam t_off_tab  OFF_TAB  = build_off_tab();
    localparam t_link_tab LINK_TAB = build_link_tab();

endpackage

### rtl/rqts_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rqts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rotating_queue_task_scheduler.sv
// Top level of the rotating queue task scheduler.
`timescale 1ns / 1ps

// The scheduler keeps thread ids in linked FIFO queues: a real-time queue, an
// idle queue and a ring of standard queues, with the successor links held in a
// link memory with one registered read port. It works on one transaction at a
// time. The result of a transaction enters the output register from the execute
// state once that register is free. A next whose chosen queue keeps further
// entries then passes through a link state, because its new head must be read
// back from the link memory. The next input transaction is taken once the block
// is idle again, even while the result still waits in the output register. A
// result that is stalled holds the block in its execute state until the output
// register frees. The time slice is held in a register of its own, loaded from
// the timer frequency register. No clearing pass runs after reset.
module rotating_queue_task_scheduler
    import rqts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration and derived slice.
    logic [FREQ_W-1:0]  r_freq;
    logic [TID_W-1:0]   r_idle_id;
    logic [SLICE_W-1:0] r_slice;
    logic [2*FREQ_W-1:0] slice_prod;

    // Queue state.
    logic [TID_W-1:0] r_heads [QUEUE_COUNT];
    logic [TID_W-1:0] r_tails [QUEUE_COUNT];
    logic [LEN_W-1:0] r_lens  [QUEUE_COUNT];
    logic [LEN_W-1:0] r_std_total;
    logic [PTR_W-1:0] r_ptr;
    logic [CLS_W-1:0] r_run_cls;

    // Current transaction and pop bookkeeping.
    t_in_item         r_item;
    logic [QW-1:0]    r_pop_q;

    // Output register.
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    // Link memory ports.
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [LINK_AW-1:0] link_raddr;
    logic [TID_W-1:0]   link_rdata;

    // Decode of the current transaction.
    logic               cfg_wr;
    logic               in_fire;
    logic               out_free;
    logic               exec_fire;
    logic               is_append;
    logic               is_std;
    logic [PTR_W:0]     slot_sum;
    logic [QW-1:0]      std_slot;
    logic [QW-1:0]      app_q;
    logic               app_room;
    logic               app_preempt;
    logic               scan_found;
    logic [QW-1:0]      scan_hit;
    logic               std_pick;
    logic               pick_any;
    logic [QW-1:0]      pick_q;
    logic [CLS_W-1:0]   pick_cls;
    logic               pick_timed;

    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign in_fire   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign exec_fire = (r_state == ST_EXEC) && out_free;
    assign is_append = (r_item.command == CMD_APPEND);
    assign is_std    = (r_item.thread_class != CLS_RT) && (r_item.thread_class != CLS_IDLE);

    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Register readback.
    always_comb begin
        unique case (paddr[2])
            REG_TIMER_FREQ: prdata = r_freq;
            REG_IDLE_ID:    prdata = PDATA_W'(r_idle_id);
            default:        prdata = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq    <= '0;
            r_idle_id <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TIMER_FREQ: r_freq    <= pwdata;
                REG_IDLE_ID:    r_idle_id <= pwdata[TID_W-1:0];
                default:        r_freq    <= r_freq;
            endcase
        end
    end

    // Time slice is the frequency divided by 100, by reciprocal multiplication.
    assign slice_prod = (2*FREQ_W)'(r_freq) * (2*FREQ_W)'(SLICE_MUL);

    always_ff @(posedge i_clk) begin
        r_slice <= slice_prod[SLICE_SHIFT +: SLICE_W];
    end

    // Standard ring slot of an append.
    always_comb begin
        slot_sum = {1'b0, r_ptr} + {1'b0, OFF_TAB[r_item.slot_offset]};
        if (slot_sum >= (PTR_W+1)'(RING_SLOTS)) begin
            slot_sum = slot_sum - (PTR_W+1)'(RING_SLOTS);
        end
        std_slot = QW'(slot_sum);
    end

    // Target queue, room check and preemption for an append.
    always_comb begin
        case (r_item.thread_class)
            CLS_RT:   app_q = RT_QUEUE;
            CLS_IDLE: app_q = IDLE_QUEUE;
            default:  app_q = std_slot;
        endcase
        app_room = (r_lens[app_q] != LEN_MAX) && (!is_std || (r_std_total != LEN_MAX));
        case (r_item.thread_class)
            CLS_RT:   app_preempt = app_room && (r_run_cls != CLS_RT);
            CLS_IDLE: app_preempt = 1'b0;
            default:  app_preempt = app_room && (r_run_cls == CLS_IDLE);
        endcase
    end

    // Scan the ring from the pointer for the first filled slot.
    always_comb begin
        logic [PTR_W:0] idx;
        scan_found = 1'b0;
        scan_hit   = '0;
        for (int n = 0; n < RING_SLOTS; n++) begin
            idx = {1'b0, r_ptr} + (PTR_W+1)'(n);
            if (idx >= (PTR_W+1)'(RING_SLOTS)) begin
                idx = idx - (PTR_W+1)'(RING_SLOTS);
            end
            if (!scan_found && (r_lens[QW'(idx)] != '0)) begin
                scan_found = 1'b1;
                scan_hit   = QW'(idx);
            end
        end
        std_pick = (r_std_total != '0) && scan_found;
    end

    // Selection for a next command.
    always_comb begin
        pick_any   = 1'b1;
        pick_q     = IDLE_QUEUE;
        pick_cls   = CLS_IDLE;
        pick_timed = 1'b1;
        if (r_lens[RT_QUEUE] != '0) begin
            pick_q     = RT_QUEUE;
            pick_cls   = CLS_RT;
            pick_timed = 1'b0;
        end else if (std_pick) begin
            pick_q   = scan_hit;
            pick_cls = CLS_STD;
        end else if (r_lens[IDLE_QUEUE] == '0) begin
            pick_any   = 1'b0;
            pick_timed = 1'b0;
        end
    end

    // Result of the current transaction.
    always_comb begin
        n_out_item = '0;
        if (is_append) begin
            n_out_item.preempt = app_preempt;
        end else begin
            n_out_item.next_thread = pick_any ? r_heads[pick_q] : r_idle_id;
            n_out_item.slice_ticks = pick_timed ? r_slice : '0;
        end
    end

    // Link memory: appends write the old tail's link, pops read the head's link.
    assign link_we    = exec_fire && is_append && app_room && (r_lens[app_q] != '0);
    assign link_waddr = LINK_TAB[r_tails[app_q]];
    assign link_raddr = LINK_TAB[r_heads[pick_q]];

    rqts_ram #(
        .WIDTH (TID_W),
        .DEPTH (MAX_THREADS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (r_item.thread_id),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    if (!is_append && pick_any && (r_lens[pick_q] > LEN_W'(1))) begin
                        n_state = ST_LINK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_LINK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State machine and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (exec_fire) begin
            r_out_item <= n_out_item;
        end
        if (in_fire) begin
            r_item <= i_in_item;
        end
        if (exec_fire) begin
            r_pop_q <= pick_q;
        end
    end

    // Queue lengths, totals, ring pointer and running class.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_lens[q] <= '0;
            end
            r_std_total <= '0;
            r_ptr       <= '0;
            r_run_cls   <= CLS_IDLE;
        end else if (exec_fire) begin
            if (is_append) begin
                if (app_room) begin
                    r_lens[app_q] <= r_lens[app_q] + LEN_W'(1);
                    if (is_std) begin
                        r_std_total <= r_std_total + LEN_W'(1);
                    end
                end
            end else begin
                r_run_cls <= pick_cls;
                if (pick_any) begin
                    r_lens[pick_q] <= r_lens[pick_q] - LEN_W'(1);
                end
                // The ring only moves when a standard thread is the one picked.
                if (pick_cls == CLS_STD) begin
                    r_std_total <= r_std_total - LEN_W'(1);
                    r_ptr       <= PTR_W'(scan_hit);
                end
            end
        end
    end

    // Queue heads and tails.
    always_ff @(posedge i_clk) begin
        if (exec_fire && is_append && app_room) begin
            r_tails[app_q] <= r_item.thread_id;
            if (r_lens[app_q] == '0) begin
                r_heads[app_q] <= r_item.thread_id;
            end
        end
        if (r_state == ST_LINK) begin
            r_heads[r_pop_q] <= link_rdata;
        end
    end

endmodule

### rtl/rqts_checker.sv
// Port-level assertions for the rotating queue task scheduler, bound to the top level.
`timescale 1ns / 1ps

module rqts_assertions
    import rqts_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_item
);

    // A stalled result keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One transaction at a time: an accepted item blocks the input next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a transaction is in flight");

    // Preemption only comes from an append, whose pick fields are zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.preempt |->
            (o_out_item.next_thread == '0) && (o_out_item.slice_ticks == '0))
        else $error("preempt with nonzero pick fields");

    // A time slice never exceeds the largest frequency divided by 100.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.slice_ticks <= SLICE_W'(42949672))
        else $error("time slice out of range");

    // Reset empties the output register.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rotating_queue_task_scheduler rqts_assertions u_rqts_assertions (.*);

### bench/rqts_checker.sv
// Checker that predicts every scheduler result and compares it with the block's output.
`timescale 1ns / 1ps

module rqts_checker
    import rqts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel, observed only.
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    // Result channel, observed only.
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    // Configuration port, observed only.
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_pready,
    // Status handed to the testbench top.
    output int                 o_pending,
    output int                 o_mismatches
);

    localparam int SLICE_DIVISOR = 100;

    // Shadow copy of the scheduler state and its registers.
    logic [TID_W-1:0]  link_mem   [MAX_THREADS];
    logic [TID_W-1:0]  q_head     [QUEUE_COUNT];
    logic [TID_W-1:0]  q_tail     [QUEUE_COUNT];
    logic [LEN_W-1:0]  q_len      [QUEUE_COUNT];
    logic [LEN_W-1:0]  ring_count;
    logic [PTR_W-1:0]  ring_ptr;
    logic [CLS_W-1:0]  running_cls;
    logic [FREQ_W-1:0] freq_reg;
    logic [TID_W-1:0]  idle_tid_reg;

    t_out_item expected_results[$];
    int        errors;

    // Link a thread behind the tail of a queue; a full queue refuses it.
    function automatic logic enqueue_thread(int q, logic [TID_W-1:0] tid);
        if (q_len[q] == LEN_MAX) return 1'b0;
        if (q_len[q] == '0) q_head[q] = tid;
        else link_mem[q_tail[q]] = tid;
        q_tail[q] = tid;
        q_len[q]  = q_len[q] + LEN_W'(1);
        return 1'b1;
    endfunction

    // Remove the head of a queue and follow its link when more entries remain.
    function automatic logic [TID_W-1:0] dequeue_thread(int q);
        logic [TID_W-1:0] tid;
        tid = q_head[q];
        if (q_len[q] > 1) q_head[q] = link_mem[tid];
        q_len[q] = q_len[q] - LEN_W'(1);
        return tid;
    endfunction

    // Apply one command to the shadow state and return the result it gives.
    function automatic t_out_item schedule_command(t_in_item it);
        t_out_item r;
        int        slot;
        logic      found;
        logic      pushed;
        r     = '0;
        found = 1'b0;
        if (it.command == CMD_APPEND) begin
            if (it.thread_class == CLS_RT) begin
                pushed = enqueue_thread(RT_QUEUE, it.thread_id);
                r.preempt = pushed && (running_cls != CLS_RT);
            end else if (it.thread_class == CLS_IDLE) begin
                void'(enqueue_thread(IDLE_QUEUE, it.thread_id));
            end else begin
                // Standard class, and the unused fourth class with it.
                slot = (int'(ring_ptr) + int'(it.slot_offset)) % RING_SLOTS;
                if (ring_count != LEN_MAX) begin
                    if (enqueue_thread(slot, it.thread_id)) begin
                        ring_count = ring_count + LEN_W'(1);
                        r.preempt  = (running_cls == CLS_IDLE);
                    end
                end
            end
        end else begin
            if (q_len[RT_QUEUE] != '0) begin
                r.next_thread = dequeue_thread(RT_QUEUE);
                running_cls   = CLS_RT;
                found         = 1'b1;
            end else if (ring_count != '0) begin
                // Scan the ring from the pointer; the pointer stays on the slot served.
                slot = int'(ring_ptr) % RING_SLOTS;
                for (int n = 0; n < RING_SLOTS && !found; n++) begin
                    if (q_len[slot] != '0) begin
                        r.next_thread = dequeue_thread(slot);
                        r.slice_ticks = SLICE_W'(freq_reg / SLICE_DIVISOR);
                        ring_count    = ring_count - LEN_W'(1);
                        running_cls   = CLS_STD;
                        found         = 1'b1;
                    end else begin
                        slot = (slot + 1) % RING_SLOTS;
                    end
                end
                ring_ptr = PTR_W'(slot);
            end
            if (!found) begin
                if (q_len[IDLE_QUEUE] != '0) begin
                    r.next_thread = dequeue_thread(IDLE_QUEUE);
                    r.slice_ticks = SLICE_W'(freq_reg / SLICE_DIVISOR);
                end else begin
                    r.next_thread = idle_tid_reg;
                end
                running_cls = CLS_IDLE;
            end
        end
        return r;
    endfunction

    // Report one field that differs from its prediction.
    function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
        if (want === got) return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    // Follow every transaction on the three ports at the clock edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) link_mem[i] = '0;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                q_head[q] = '0;
                q_tail[q] = '0;
                q_len[q]  = '0;
            end
            ring_count   = '0;
            ring_ptr     = '0;
            running_cls  = CLS_IDLE;
            freq_reg     = '0;
            idle_tid_reg = '0;
            expected_results.delete();
            errors = 0;
        end else begin
            // Register writes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_TIMER_FREQ: freq_reg = i_pwdata;
                    REG_IDLE_ID:    idle_tid_reg = i_pwdata[TID_W-1:0];
                    default: ;
                endcase
            end
            // Result transactions are checked against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_item);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    errors += field_differs("preempt", 32'(want.preempt),
                                            32'(i_out_item.preempt));
                    errors += field_differs("next_thread", 32'(want.next_thread),
                                            32'(i_out_item.next_thread));
                    errors += field_differs("slice_ticks", 32'(want.slice_ticks),
                                            32'(i_out_item.slice_ticks));
                end
            end
            // Input transactions produce the next prediction.
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(schedule_command(i_in_item));
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= errors;
    end

endmodule

### bench/tb.sv
// Testbench top: stimulus, idling and verdict for the rotating queue task scheduler.
`timescale 1ns / 1ps

module tb;
    import rqts_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_TIMER_FREQ = {REG_TIMER_FREQ, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_IDLE_ID    = {REG_IDLE_ID, 2'b00};
    // The fourth class code, which the block treats as standard.
    localparam logic [CLS_W-1:0]   CLS_SPARE       = 2'd3;
    localparam int                 PHASE_ITEMS     = 130;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               calm      = 1'b0;
    int                 pending_count;
    int                 mismatch_count;
    int                 stall_left = 0;
    int                 run_left   = 0;

    rotating_queue_task_scheduler DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rqts_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending_count),
        .o_mismatches (mismatch_count)
    );

    always #6 clk = ~clk;

    // Result stalls come in bursts between clear stretches, both drawn at random.
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
            stall_left = 0;
            run_left   = 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (run_left > 0) run_left--;
            else if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 11);
            else run_left = $urandom_range(1, 40);
        end
    end

    function automatic t_in_item request(logic cmd, logic [TID_W-1:0] tid,
                                         logic [CLS_W-1:0] cls, logic [OFF_W-1:0] off);
        t_in_item it;
        it.command      = cmd;
        it.thread_id    = tid;
        it.thread_class = cls;
        it.slot_offset  = off;
        return it;
    endfunction

    // A next command still carries random bits in its unused fields.
    function automatic t_in_item random_request(int next_percent);
        return request(($urandom_range(0, 99) < next_percent) ? CMD_NEXT : CMD_APPEND,
                       TID_W'($urandom), CLS_W'($urandom_range(0, 3)), OFF_W'($urandom));
    endfunction

    // Offer one transaction, after an occasional gap, and hold it until taken.
    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Overall time limit for the run.
    initial begin
        #4_000_000;
        $display("rotating_queue_task_scheduler verification failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the idle queue past its limit with consecutive ids so that every
        // link entry is written, then overfill the standard ring and empty all.
        write_register(ADDR_TIMER_FREQ, 32'd12345);
        write_register(ADDR_IDLE_ID, PDATA_W'(63));
        for (int i = 0; i < 128; i++)
            send_item(request(CMD_APPEND, TID_W'(i), CLS_IDLE, OFF_W'($urandom)));
        for (int i = 0; i < 128; i++)
            send_item(request(CMD_APPEND, TID_W'($urandom),
                              $urandom_range(0, 1) ? CLS_STD : CLS_SPARE,
                              OFF_W'($urandom)));
        for (int i = 0; i < 260; i++)
            send_item(random_request(100));
        drain_results();

        // Directed sequence: preemption rules, pick order, extremes and duplicates.
        write_register(ADDR_TIMER_FREQ, 32'hFFFF_FFFF);
        write_register(ADDR_IDLE_ID, PDATA_W'(0));
        send_item(request(CMD_APPEND, 6'd0,  CLS_RT,    8'd0));
        send_item(request(CMD_NEXT,   6'd63, CLS_SPARE, 8'd255));
        send_item(request(CMD_APPEND, 6'd63, CLS_RT,    8'd255));
        send_item(request(CMD_APPEND, 6'd63, CLS_STD,   8'd255));
        send_item(request(CMD_APPEND, 6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_APPEND, 6'd1,  CLS_STD,   8'd0));
        send_item(request(CMD_APPEND, 6'd2,  CLS_RT,    8'd17));
        send_item(request(CMD_APPEND, 6'd3,  CLS_SPARE, 8'd8));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_NEXT,   6'd0,  CLS_IDLE,  8'd0));
        send_item(request(CMD_APPEND, 6'd5,  CLS_IDLE,  8'd0));
        send_item(request(CMD_APPEND, 6'd5,  CLS_IDLE,  8'd0));
        send_item(request(CMD_APPEND, 6'd42, CLS_STD,   8'd200));
        for (int i = 0; i < 4; i++)
            send_item(request(CMD_NEXT, 6'd0, CLS_IDLE, 8'd0));
        drain_results();

        // Random phases under several register settings; the last runs without idling.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_register(ADDR_TIMER_FREQ, 32'd99);
                    write_register(ADDR_IDLE_ID, PDATA_W'(63));
                end
                1: begin
                    write_register(ADDR_TIMER_FREQ, 32'd100);
                    write_register(ADDR_IDLE_ID, PDATA_W'($urandom_range(0, 63)));
                end
                2: begin
                    write_register(ADDR_TIMER_FREQ, $urandom);
                    write_register(ADDR_IDLE_ID, PDATA_W'($urandom_range(0, 63)));
                end
                default: begin
                    calm <= 1'b1;
                    write_register(ADDR_TIMER_FREQ, 32'd0);
                    write_register(ADDR_IDLE_ID, PDATA_W'($urandom_range(0, 63)));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_request(45));
                if (phase == 0 && i == PHASE_ITEMS / 2) drain_results();
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("rotating_queue_task_scheduler verification clean");
        end else begin
            $display("rotating_queue_task_scheduler verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rqts_pkg.sv
rtl/rqts_ram.sv
rtl/rotating_queue_task_scheduler.sv
rtl/rqts_checker.sv
bench/rqts_checker.sv
bench/tb.sv
